@@ rtl/i2c_master_byte_engine_defines.svh @@
// Assertion macros shared by the I2C master byte engine RTL.
// No dependencies; each macro expects signals named clk and rst in scope.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define I2CMBE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CMBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/i2cmbe_pkg.sv @@
// Package for the I2C master byte engine: request codes, line levels,
// phase tables and the per-phase line update. No dependencies.
package i2cmbe_pkg;

  // Request and command codes; REQ_NONE also marks the idle engine.
  typedef enum logic [2:0] {
    REQ_NONE  = 3'd0,
    REQ_START = 3'd1,
    REQ_STOP  = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_READ  = 3'd4
  } req_t;

  localparam int unsigned PhaseW = 5;
  localparam int unsigned TickW  = 16;
  localparam logic [TickW-1:0] PhaseTicksReset = 16'd5;

  // Levels of the two bus lines, 1 released and 0 driven low.
  typedef struct packed {
    logic scl;
    logic sda;
  } lines_t;

  // Number of bus phases in each command.
  function automatic logic [PhaseW-1:0] phase_count(req_t cmd);
    logic [PhaseW-1:0] n;
    case (cmd)
      REQ_START: n = 5'd4;
      REQ_STOP:  n = 5'd3;
      REQ_WRITE: n = 5'd27;
      REQ_READ:  n = 5'd20;
      default:   n = 5'd0;
    endcase
    return n;
  endfunction

  // Bit number of a write data phase: k / 3 for k below 24, via k * 11 >> 5.
  function automatic logic [2:0] write_bit(logic [PhaseW-1:0] k);
    logic [8:0] prod;
    prod = 9'(k) * 9'd11;
    return prod[7:5];
  endfunction

  // Line levels after applying phase k of a command.
  function automatic lines_t apply_phase(req_t cmd, logic [PhaseW-1:0] k,
                                         logic [7:0] shift, logic nack,
                                         lines_t cur);
    lines_t     res;
    logic [2:0] bit_idx;
    logic [4:0] sub;
    res     = cur;
    bit_idx = write_bit(k);
    sub     = k - 5'(bit_idx) * 5'd3;
    case (cmd)
      REQ_START: begin
        if (k == 5'd0)      res.sda = 1'b1;
        else if (k == 5'd1) res.scl = 1'b1;
        else if (k == 5'd2) res.sda = 1'b0;
        else                res.scl = 1'b0;
      end
      REQ_STOP: begin
        if (k == 5'd0)      res.sda = 1'b0;
        else if (k == 5'd1) res.scl = 1'b1;
        else                res.sda = 1'b1;
      end
      REQ_WRITE: begin
        if (k < 5'd24) begin
          if (sub == 5'd0)      res.sda = shift[~bit_idx];
          else if (sub == 5'd1) res.scl = 1'b1;
          else                  res.scl = 1'b0;
        end else if (k == 5'd24) begin
          res.sda = 1'b1;
        end else if (k == 5'd25) begin
          res.scl = 1'b1;
        end else begin
          res.scl = 1'b0;
        end
      end
      REQ_READ: begin
        if (k == 5'd0) begin
          res.sda = 1'b1;
        end else if (k <= 5'd16) begin
          res.scl = k[0];
        end else if (k == 5'd17) begin
          res.sda = nack;
        end else if (k == 5'd18) begin
          res.scl = 1'b1;
        end else begin
          res.scl = 1'b0;
          res.sda = 1'b1;
        end
      end
      default: res = cur;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/i2c_master_byte_engine.sv @@
// I2C master byte engine: phase sequencer for start, stop, byte write and read.
// Depends on i2cmbe_pkg and i2c_master_byte_engine_defines.svh.
//
// Usage: every beat on the input channel (in_valid/in_ready) is one system
// tick carrying the sampled SDA level and an optional request in req_type.
// Each input beat yields exactly one output beat (out_valid/out_ready) with
// the SCL/SDA levels, busy and done flags, the last read byte and the last
// write ACK sample. A request is taken only on a tick that finds the engine
// idle; requests while busy are dropped. phase_ticks, written through the
// cfg_valid/cfg_ready/cfg_data port, sets the ticks per bus phase (0 acts
// as 1). The sequencer state and the output beat are updated together at the
// accepting edge, so the result is registered; a new tick is accepted every
// cycle while the receiver keeps up. If the receiver stalls, the output beat
// holds and in_ready stays low, so no further tick is taken until that beat
// is accepted. Reset releases both lines, idles the sequencer and sets
// phase_ticks to 5.
`include "i2c_master_byte_engine_defines.svh"

module i2c_master_byte_engine
  import i2cmbe_pkg::*;
#(
  parameter logic [TickW-1:0] PHASE_TICKS_RESET = PhaseTicksReset
) (
  input  logic             clk,
  input  logic             rst,
  // Configuration write port
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TickW-1:0] cfg_data,
  // Tick input channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       req_type,
  input  logic [7:0]       write_data,
  input  logic             send_nack,
  input  logic             sda_in,
  // Result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic             scl_out,
  output logic             sda_out,
  output logic             busy_res,
  output logic             done_res,
  output logic [7:0]       read_data,
  output logic             ack_bit
);

  logic [TickW-1:0]  phase_ticks;
  req_t              cmd, cmd_next;
  logic [PhaseW-1:0] step, step_next;
  logic [TickW-1:0]  div, div_next;
  logic [7:0]        shift, shift_next;
  lines_t            lines, lines_next;
  logic              ack, ack_next;
  logic              nack_hold, nack_hold_next;
  logic [7:0]        last_read, last_read_next;
  logic              done, done_next;
  logic              in_beat;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_beat   = in_valid && in_ready;

  // Sequencer next state for one tick.
  always_comb begin
    logic [TickW-1:0]  period;
    logic [TickW:0]    div_inc;
    logic [PhaseW-1:0] step_inc;
    cmd_next       = cmd;
    step_next      = step;
    div_next       = div;
    shift_next     = shift;
    lines_next     = lines;
    ack_next       = ack;
    nack_hold_next = nack_hold;
    last_read_next = last_read;
    done_next      = 1'b0;
    period         = (phase_ticks == '0) ? TickW'(1) : phase_ticks;
    div_inc        = {1'b0, div} + (TickW+1)'(1);
    step_inc       = step + PhaseW'(1);
    if (cmd == REQ_NONE) begin
      // Idle: take a known request and apply its first phase at once.
      if (req_type >= 3'(REQ_START) && req_type <= 3'(REQ_READ)) begin
        cmd_next       = req_t'(req_type);
        step_next      = '0;
        div_next       = '0;
        shift_next     = (req_type == 3'(REQ_WRITE)) ? write_data : 8'd0;
        nack_hold_next = send_nack;
        lines_next     = apply_phase(req_t'(req_type), '0, shift_next, send_nack,
                                     lines);
      end
    end else if (div_inc >= {1'b0, period}) begin
      // Phase ends: sample SDA where the phase was an SCL-high sample point.
      div_next = '0;
      if (cmd == REQ_WRITE && step == 5'd25) begin
        ack_next = sda_in;
      end else if (cmd == REQ_READ && step[0] && step <= 5'd15) begin
        shift_next = {shift[6:0], sda_in};
      end
      if (step_inc >= phase_count(cmd)) begin
        if (cmd == REQ_READ) last_read_next = shift_next;
        cmd_next  = REQ_NONE;
        step_next = '0;
        done_next = 1'b1;
      end else begin
        step_next  = step_inc;
        lines_next = apply_phase(cmd, step_inc, shift_next, nack_hold, lines);
      end
    end else begin
      div_next = div_inc[TickW-1:0];
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      phase_ticks <= cfg_data;
    end
  end

  // Sequencer state and the done flag advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd       <= REQ_NONE;
      step      <= '0;
      div       <= '0;
      shift     <= '0;
      lines     <= '{scl: 1'b1, sda: 1'b1};
      ack       <= 1'b0;
      nack_hold <= 1'b0;
      last_read <= '0;
      done      <= 1'b0;
    end else if (in_beat) begin
      cmd       <= cmd_next;
      step      <= step_next;
      div       <= div_next;
      shift     <= shift_next;
      lines     <= lines_next;
      ack       <= ack_next;
      nack_hold <= nack_hold_next;
      last_read <= last_read_next;
      done      <= done_next;
    end
  end

  // Output beat valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The state registers hold steady until the next accepted beat.
  assign scl_out   = lines.scl;
  assign sda_out   = lines.sda;
  assign busy_res  = (cmd != REQ_NONE);
  assign done_res  = done;
  assign read_data = last_read;
  assign ack_bit   = ack;

  `I2CMBE_ASSERT_NOW(a_idle_clean, cmd == REQ_NONE, step == '0 && div == '0,
    "idle engine with nonzero phase or divider")
  `I2CMBE_ASSERT_NOW(a_step_range, cmd != REQ_NONE, step < phase_count(cmd),
    "phase step beyond command length")
  `I2CMBE_ASSERT_NOW(a_done_idle, done, cmd == REQ_NONE,
    "done flagged while a command is still active")
  `I2CMBE_ASSERT_NEXT(a_start_busy,
    in_beat && cmd == REQ_NONE && req_type == 3'(REQ_START),
    busy_res && out_valid && !sda_out == 1'b0,
    "start request did not make the engine busy")

endmodule
